[src/mphp_pkg.sv]
// mphp_pkg: shared types and constants for the media packet header parser.
// Holds the result record, result kind codes, register indexes and header checks.
// No dependencies.
package mphp_pkg;

	localparam logic [2:0] KIND_HEADER      = 3'd0;
	localparam logic [2:0] KIND_BODY        = 3'd1;
	localparam logic [2:0] KIND_BAD_MARK    = 3'd2;
	localparam logic [2:0] KIND_BAD_FIXED   = 3'd3;
	localparam logic [2:0] KIND_BAD_PTYPE   = 3'd4;
	localparam logic [2:0] KIND_BAD_DTYPE   = 3'd5;
	localparam logic [2:0] KIND_BAD_SPLIT   = 3'd6;
	localparam logic [2:0] KIND_TOO_LONG    = 3'd7;

	localparam logic [1:0] REG_HEAD_MARK    = 2'd0;
	localparam logic [1:0] REG_MAX_LEN      = 2'd1;

	localparam logic [31:0] HEAD_MARK_RST   = 32'h3031_6364;
	localparam logic [9:0]  MAX_LEN_RST     = 10'd950;
	localparam logic [15:0] BODY_LIMIT_MAX  = 16'd1023;

	// V=2, P=0, X=0, CC=1
	localparam logic [7:0] FIXED_BITS       = 8'h81;
	localparam logic [3:0] DTYPE_MAX        = 4'd4;
	localparam logic [3:0] DTYPE_AUDIO      = 4'd3;
	localparam logic [3:0] DTYPE_VIDEO_MAX  = 4'd2;
	localparam logic [3:0] SPLIT_MAX        = 4'd3;
	localparam logic [3:0] LENPOS_VIDEO     = 4'd12;
	localparam logic [3:0] LENPOS_AUDIO     = 4'd8;
	localparam logic [3:0] LENPOS_PASS      = 4'd0;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  body_byte;
		logic        last;
		logic [7:0]  marker_and_type;
		logic [15:0] sequence_res;
		logic [47:0] sim_bcd;
		logic [7:0]  channel;
		logic [7:0]  type_and_split;
		logic [63:0] timestamp;
		logic [15:0] key_frame_gap;
		logic [15:0] frame_gap;
		logic [9:0]  body_length;
	} res_t;

	function automatic logic ptype_ok(input logic [6:0] pt);
		logic ok;
		ok = pt inside {7'd6, 7'd7, 7'd8, 7'd26, 7'd91, 7'd98};
		return ok;
	endfunction

endpackage

[src/mphp_parse_core.sv]
// mphp_parse_core: per-byte header parsing state and result formation.
// One byte is consumed per step; the result is combinational from state and byte.
// Depends on mphp_pkg.
module mphp_parse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data,
	input  logic [31:0]         head_mark,
	input  logic [9:0]          max_len,
	output mphp_pkg::res_t      res,
	output logic                res_valid
);

	typedef enum logic [1:0] {
		PH_FIXED = 2'd0,
		PH_VAR   = 2'd1,
		PH_BODY  = 2'd2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  idx_q, idx_d;
	logic [9:0]  remain_q, remain_d;
	logic [31:0] mark_q, mark_d;
	logic [7:0]  mt_q, mt_d;
	logic [15:0] seq_q, seq_d;
	logic [47:0] sim_q, sim_d;
	logic [7:0]  chan_q, chan_d;
	logic [7:0]  split_q, split_d;
	logic [63:0] tstamp_q, tstamp_d;
	logic [31:0] gaps_q, gaps_d;
	logic [7:0]  len_hi_q, len_hi_d;

	logic        err;
	logic [2:0]  err_kind;
	logic [3:0]  lenpos;
	logic [15:0] len_full;

	always_comb begin
		if (split_q[7:4] <= mphp_pkg::DTYPE_VIDEO_MAX) begin
			lenpos = mphp_pkg::LENPOS_VIDEO;
		end else if (split_q[7:4] == mphp_pkg::DTYPE_AUDIO) begin
			lenpos = mphp_pkg::LENPOS_AUDIO;
		end else begin
			lenpos = mphp_pkg::LENPOS_PASS;
		end
		len_full = {len_hi_q, data};
	end

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		remain_d  = remain_q;
		mark_d    = mark_q;
		mt_d      = mt_q;
		seq_d     = seq_q;
		sim_d     = sim_q;
		chan_d    = chan_q;
		split_d   = split_q;
		tstamp_d  = tstamp_q;
		gaps_d    = gaps_q;
		len_hi_d  = len_hi_q;
		err       = 1'b0;
		err_kind  = mphp_pkg::KIND_BAD_MARK;
		res       = '0;
		res_valid = 1'b0;

		case (phase_q)
			PH_FIXED: begin
				idx_d = idx_q + 4'd1;
				if (idx_q == 4'd0) begin
					tstamp_d = '0;
					gaps_d   = '0;
				end
				case (idx_q) inside
					[4'd0:4'd3]: begin
						mark_d = {mark_q[23:0], data};
						if (idx_q == 4'd3 && mark_d != head_mark) begin
							err      = 1'b1;
							err_kind = mphp_pkg::KIND_BAD_MARK;
						end
					end
					4'd4: begin
						if (data != mphp_pkg::FIXED_BITS) begin
							err      = 1'b1;
							err_kind = mphp_pkg::KIND_BAD_FIXED;
						end
					end
					4'd5: begin
						if (!mphp_pkg::ptype_ok(data[6:0])) begin
							err      = 1'b1;
							err_kind = mphp_pkg::KIND_BAD_PTYPE;
						end
						mt_d = data;
					end
					[4'd6:4'd7]: begin
						seq_d = {seq_q[7:0], data};
					end
					[4'd8:4'd13]: begin
						sim_d = {sim_q[39:0], data};
					end
					4'd14: begin
						chan_d = data;
					end
					default: begin
						if (data[7:4] > mphp_pkg::DTYPE_MAX) begin
							err      = 1'b1;
							err_kind = mphp_pkg::KIND_BAD_DTYPE;
						end else if (data[3:0] > mphp_pkg::SPLIT_MAX) begin
							err      = 1'b1;
							err_kind = mphp_pkg::KIND_BAD_SPLIT;
						end else begin
							split_d = data;
							phase_d = PH_VAR;
							idx_d   = '0;
						end
					end
				endcase
			end
			PH_VAR: begin
				if (idx_q < lenpos) begin
					if (idx_q < 4'd8) begin
						tstamp_d = {tstamp_q[55:0], data};
					end else begin
						gaps_d = {gaps_q[23:0], data};
					end
					idx_d = idx_q + 4'd1;
				end else if (idx_q == lenpos) begin
					len_hi_d = data;
					idx_d    = idx_q + 4'd1;
				end else if (len_full > {6'd0, max_len} || len_full > mphp_pkg::BODY_LIMIT_MAX) begin
					err      = 1'b1;
					err_kind = mphp_pkg::KIND_TOO_LONG;
				end else begin
					res_valid           = 1'b1;
					res.kind            = mphp_pkg::KIND_HEADER;
					res.marker_and_type = mt_q;
					res.sequence_res    = seq_q;
					res.sim_bcd         = sim_q;
					res.channel         = chan_q;
					res.type_and_split  = split_q;
					res.timestamp       = tstamp_q;
					res.key_frame_gap   = gaps_q[31:16];
					res.frame_gap       = gaps_q[15:0];
					res.body_length     = len_full[9:0];
					idx_d               = '0;
					if (len_full == 16'd0) begin
						res.last = 1'b1;
						phase_d  = PH_FIXED;
					end else begin
						remain_d = len_full[9:0];
						phase_d  = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				res_valid     = 1'b1;
				res.kind      = mphp_pkg::KIND_BODY;
				res.body_byte = data;
				if (remain_q != 10'd0) begin
					remain_d = remain_q - 10'd1;
				end
				if (remain_d == 10'd0) begin
					res.last = 1'b1;
					phase_d  = PH_FIXED;
					idx_d    = '0;
				end
			end
			default: begin
				phase_d = PH_FIXED;
				idx_d   = '0;
			end
		endcase

		if (err) begin
			res       = '0;
			res.kind  = err_kind;
			res.last  = 1'b1;
			res_valid = 1'b1;
			phase_d   = PH_FIXED;
			idx_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIXED;
			idx_q    <= '0;
			remain_q <= '0;
			mark_q   <= '0;
			tstamp_q <= '0;
			gaps_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			idx_q    <= idx_d;
			remain_q <= remain_d;
			mark_q   <= mark_d;
			tstamp_q <= tstamp_d;
			gaps_q   <= gaps_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			mt_q     <= mt_d;
			seq_q    <= seq_d;
			sim_q    <= sim_d;
			chan_q   <= chan_d;
			split_q  <= split_d;
			len_hi_q <= len_hi_d;
		end
	end

endmodule

[src/media_packet_header_parser.sv]
// media_packet_header_parser: top level with input register, result register,
// configuration registers and the parsing core. Depends on mphp_pkg, mphp_parse_core.
//
// Takes one stream byte per clock while byte_stall is low and returns at most one
// result per byte: a header record once the body length is in, one record per
// body byte (the final one flagged last), or an error code with last set, after
// which parsing starts over at the next byte. Sustained rate is one byte per cycle
// while result_stall stays low; a byte's result passes through the input register
// and then the result register before it is valid.
// Bytes that produce no result still pass through the core in order, so a
// stalled result output holds the input register and stalls the byte channel.
// Configuration is written through cfg_valid/cfg_ready, which is always ready.
module media_packet_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  result_kind,
	output logic [7:0]  body_byte,
	output logic        last,
	output logic [7:0]  marker_and_type,
	output logic [15:0] sequence_res,
	output logic [47:0] sim_bcd,
	output logic [7:0]  channel,
	output logic [7:0]  type_and_split,
	output logic [63:0] timestamp,
	output logic [15:0] key_frame_gap,
	output logic [15:0] frame_gap,
	output logic [9:0]  body_length
);

	logic [31:0]     head_mark_q;
	logic [9:0]      max_len_q;
	logic            in_v_s1;
	logic [7:0]      in_byte_s1;
	logic            out_v_q;
	mphp_pkg::res_t  out_res_q;
	mphp_pkg::res_t  core_res;
	logic            core_res_v;
	logic            adv;
	logic            step;

	assign cfg_ready  = 1'b1;
	assign adv        = !out_v_q || !result_stall;
	assign step       = in_v_s1 && adv;
	assign byte_stall = in_v_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_mark_q <= mphp_pkg::HEAD_MARK_RST;
			max_len_q   <= mphp_pkg::MAX_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mphp_pkg::REG_HEAD_MARK: head_mark_q <= cfg_data;
				mphp_pkg::REG_MAX_LEN:   max_len_q   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (!byte_stall) begin
			in_v_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			in_byte_s1 <= data_byte;
		end
	end

	mphp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data      (in_byte_s1),
		.head_mark (head_mark_q),
		.max_len   (max_len_q),
		.res       (core_res),
		.res_valid (core_res_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= step && core_res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (step && core_res_v) begin
			out_res_q <= core_res;
		end
	end

	assign result_valid    = out_v_q;
	assign result_kind     = out_res_q.kind;
	assign body_byte       = out_res_q.body_byte;
	assign last            = out_res_q.last;
	assign marker_and_type = out_res_q.marker_and_type;
	assign sequence_res    = out_res_q.sequence_res;
	assign sim_bcd         = out_res_q.sim_bcd;
	assign channel         = out_res_q.channel;
	assign type_and_split  = out_res_q.type_and_split;
	assign timestamp       = out_res_q.timestamp;
	assign key_frame_gap   = out_res_q.key_frame_gap;
	assign frame_gap       = out_res_q.frame_gap;
	assign body_length     = out_res_q.body_length;

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind != mphp_pkg::KIND_HEADER &&
		 result_kind != mphp_pkg::KIND_BODY) |-> last)
		else $error("error result without last");

	a_body_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind != mphp_pkg::KIND_BODY) |-> (body_byte == 8'd0))
		else $error("body byte set on non-body result");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (in_v_s1 && out_v_q && result_stall))
		else $error("byte channel stalled without a held result");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> $stable(out_res_q) && byte_stall == (in_v_s1 && result_stall))
		else $error("held result changed");

endmodule
